FILE: design/mbrc_pkg.sv
// shared types, constants and the crc step for the modbus rtu response checker
`default_nettype none
package mbrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 9;
    localparam int LEN_W      = POS_W + 1;

    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam logic [15:0]      CRC_INIT   = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY   = 16'hA001;
    localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_HDRCRC = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_ECHO   = LEN_W'(8);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLAVE_ADDR  = 3'd0,
        REG_FUNC_CODE   = 3'd1,
        REG_START_ADDR  = 3'd2,
        REG_ITEM_QTY    = 3'd3,
        REG_WRITTEN_VAL = 3'd4
    } t_cfg_idx;

    // modbus function codes with special handling
    localparam logic [6:0] FC_READ_COILS = 7'd1;
    localparam logic [6:0] FC_READ_HOLD  = 7'd3;
    localparam logic [6:0] FC_READ_INPUT = 7'd4;
    localparam logic [6:0] FC_WRITE_REGS = 7'd16;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FRAME_ERR = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_ADDR_ERR  = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_FUNC_ERR  = 3'd5
    } t_status;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [6:0]  function_code;
        logic [15:0] start_address;
        logic [10:0] item_quantity;
        logic [15:0] written_value;
    } t_cfg;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] data_word;
        logic [7:0]  word_index;
        logic [2:0]  frame_status;
        logic [7:0]  exc_code;
    } t_result;

    // one byte through the reflected modbus crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/mbrc_if.sv
// channel interfaces: received bytes, results and configuration writes
`default_nettype none
interface mbrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;
    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mbrc_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] data_word;
    logic [7:0]  word_index;
    logic [2:0]  frame_status;
    logic [7:0]  exc_code;
    modport source (output valid, output result_kind, output data_word, output word_index,
                    output frame_status, output exc_code, input ready);
    modport sink   (input valid, input result_kind, input data_word, input word_index,
                    input frame_status, input exc_code, output ready);
endinterface

interface mbrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/mbrc_cfg_regs.sv
// configuration register file holding the outstanding request
`default_nettype none
module mbrc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr,
    input  wire logic [mbrc_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [mbrc_pkg::CFG_DATA_W-1:0]  i_data,
    output mbrc_pkg::t_cfg                        o_cfg
);
    import mbrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= 8'd1;
            r_cfg.function_code <= FC_READ_HOLD;
            r_cfg.start_address <= 16'd0;
            r_cfg.item_quantity <= 11'd1;
            r_cfg.written_value <= 16'd0;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_idx))
                REG_SLAVE_ADDR:  r_cfg.slave_address <= i_data[7:0];
                REG_FUNC_CODE:   r_cfg.function_code <= i_data[6:0];
                REG_START_ADDR:  r_cfg.start_address <= i_data;
                REG_ITEM_QTY:    r_cfg.item_quantity <= i_data[10:0];
                REG_WRITTEN_VAL: r_cfg.written_value <= i_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

FILE: design/mbrc_frame.sv
// per-frame state, crc and result decision for one received byte
`default_nettype none
module mbrc_frame (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_eof,
    input  mbrc_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output mbrc_pkg::t_result o_result
);
    import mbrc_pkg::*;

    logic [15:0]      r_crc,   n_crc;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_addr,  n_addr;
    logic [7:0]       r_func,  n_func;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_high,  n_high;
    logic [15:0]      r_echo1, n_echo1;
    logic [15:0]      r_echo2, n_echo2;

    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] off;
    logic             is_reg_read;
    logic             func_match;
    logic             in_payload;
    logic [7:0]       coil_bytes;
    t_status          status;
    logic [7:0]       exc;

    assign is_reg_read = (i_cfg.function_code == FC_READ_HOLD) ||
                         (i_cfg.function_code == FC_READ_INPUT);
    assign coil_bytes  = 8'((12'(i_cfg.item_quantity) + 12'd7) >> 3);

    always_comb begin
        n_crc   = crc_byte(r_crc, i_rx_byte);
        n_addr  = r_addr;
        n_func  = r_func;
        n_count = r_count;
        n_echo1 = r_echo1;
        n_echo2 = r_echo2;
        if (r_pos == POS_W'(0)) begin
            n_addr = i_rx_byte;
        end else if (r_pos == POS_W'(1)) begin
            n_func = i_rx_byte;
        end else if (r_pos == POS_W'(2)) begin
            n_count = i_rx_byte;
            n_echo1 = {i_rx_byte, r_echo1[7:0]};
        end else if (r_pos == POS_W'(3)) begin
            n_echo1 = {r_echo1[15:8], i_rx_byte};
        end else if (r_pos == POS_W'(4)) begin
            n_echo2 = {i_rx_byte, r_echo2[7:0]};
        end else if (r_pos == POS_W'(5)) begin
            n_echo2 = {r_echo2[15:8], i_rx_byte};
        end
    end

    assign len        = LEN_W'(r_pos) + LEN_W'(1);
    assign off        = r_pos - POS_W'(3);
    assign func_match = (n_func == {1'b0, i_cfg.function_code});
    assign in_payload = (r_pos >= POS_W'(3)) && (off < POS_W'(n_count)) && func_match;

    // status precedence on the closing byte
    always_comb begin
        status = ST_OK;
        exc    = 8'd0;
        if (len < LEN_MIN) begin
            status = ST_FRAME_ERR;
        end else if (n_crc != 16'd0) begin
            status = ST_CRC_ERR;
        end else if (n_addr != i_cfg.slave_address) begin
            status = ST_ADDR_ERR;
        end else if (n_func == {1'b1, i_cfg.function_code}) begin
            if (len != LEN_HDRCRC) begin
                status = ST_FRAME_ERR;
            end else begin
                status = ST_EXCEPTION;
                exc    = n_count;
            end
        end else if (!func_match) begin
            status = ST_FUNC_ERR;
        end else if (is_reg_read) begin
            if ((12'(n_count) != {i_cfg.item_quantity, 1'b0}) ||
                (len != LEN_W'(n_count) + LEN_HDRCRC)) begin
                status = ST_FRAME_ERR;
            end
        end else if (i_cfg.function_code == FC_READ_COILS) begin
            if ((n_count != coil_bytes) || (len != LEN_W'(n_count) + LEN_HDRCRC)) begin
                status = ST_FRAME_ERR;
            end
        end else begin
            if ((len != LEN_ECHO) || (n_echo1 != i_cfg.start_address)) begin
                status = ST_FRAME_ERR;
            end else if (i_cfg.function_code == FC_WRITE_REGS) begin
                if (n_echo2 != 16'(i_cfg.item_quantity)) begin
                    status = ST_FRAME_ERR;
                end
            end else if (n_echo2 != i_cfg.written_value) begin
                status = ST_FRAME_ERR;
            end
        end
    end

    always_comb begin
        o_emit   = 1'b0;
        o_result = '0;
        n_high   = r_high;
        n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
        if (i_eof) begin
            o_emit                = 1'b1;
            o_result.result_kind  = KIND_STATUS;
            o_result.frame_status = status;
            o_result.exc_code     = exc;
        end else if (in_payload) begin
            if (is_reg_read) begin
                if (!off[0]) begin
                    n_high = i_rx_byte;
                end else begin
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_DATA;
                    o_result.data_word   = {r_high, i_rx_byte};
                    o_result.word_index  = off[8:1];
                end
            end else if (i_cfg.function_code == FC_READ_COILS) begin
                o_emit               = 1'b1;
                o_result.result_kind = KIND_DATA;
                o_result.data_word   = {8'd0, i_rx_byte};
                o_result.word_index  = off[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_eof)) begin
            r_crc   <= CRC_INIT;
            r_pos   <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_count <= '0;
            r_high  <= '0;
            r_echo1 <= '0;
            r_echo2 <= '0;
        end else if (i_accept) begin
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_count <= n_count;
            r_high  <= n_high;
            r_echo1 <= n_echo1;
            r_echo2 <= n_echo2;
        end
    end
endmodule
`default_nettype wire

FILE: design/modbus_rtu_response_checker.sv
// top level: modbus rtu response checker with registered result beat
// latency: a result beat is valid in the cycle after the byte beat that causes it
// throughput: one byte per cycle if the sink does not stall; the crc step and
// checks for a byte sit between the frame state registers and the result register
// reset: synchronous, active low; config returns to defaults, crc to 0xffff,
// frame position to zero, result register empties
`default_nettype none
module modbus_rtu_response_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbrc_rx_if.sink    i_rx,
    mbrc_cfg_if.sink   i_cfg,
    mbrc_res_if.source o_res
);
    import mbrc_pkg::*;

    t_cfg    cfg;
    logic    accept;
    logic    emit;
    t_result result;

    logic    r_valid;
    t_result r_res;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    mbrc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // a byte beat goes in whenever the result register is empty or drains now
    assign i_rx.ready = !r_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    mbrc_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_eof     (i_rx.end_of_frame),
        .i_cfg     (cfg),
        .o_emit    (emit),
        .o_result  (result)
    );

    // result register: loaded on a beat that produces a result, cleared when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= emit;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_res <= result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.result_kind  = r_res.result_kind;
    assign o_res.data_word    = r_res.data_word;
    assign o_res.word_index   = r_res.word_index;
    assign o_res.frame_status = r_res.frame_status;
    assign o_res.exc_code     = r_res.exc_code;
endmodule
`default_nettype wire
